@@ src/tcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg: text console cell writer shared definitions
// Payload structs, action codes, character codes and sequencer states.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Action codes of an input item
  typedef enum logic [1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } tcc_action_t;

  // Special character codes
  localparam logic [7:0] CODE_NEWLINE = 8'h0A;
  localparam logic [7:0] CODE_BLANK   = 8'h08;
  localparam logic [7:0] CODE_SPACE   = 8'h20;

  // Attribute after reset
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Input item
  typedef struct packed {
    tcc_action_t action;
    logic [7:0]  char_code;
    logic        at_cursor;
    logic [6:0]  col;
    logic [4:0]  row;
  } tcc_in_t;

  // Result item
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tcc_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,    // zero the store after reset
    ST_IDLE,    // wait for an input transfer
    ST_EXEC,    // single-cell write or read
    ST_FILL,    // clear screen sweep
    ST_SCR_RD,  // scroll: read source cell
    ST_SCR_WR,  // scroll: write cell one row up
    ST_ZERO,    // scroll: zero the last row
    ST_DONE     // hand result to output register
  } tcc_state_t;

endpackage : tcc_pkg
`default_nettype wire

@@ src/tcc_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_chan_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface tcc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : tcc_chan_if
`default_nettype wire

@@ src/text_console_cell_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer: text console with cursor
// Grid of COLUMNS x ROWS cells (attribute:char) with put, backspace, clear
// and read actions; scrolls up one row when the cursor runs off the end.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload     transfer when
//  -------  ---  ----------  ----------------------------
//  in_ch    in   tcc_in_t    valid & ready
//  out_ch   out  tcc_out_t   valid & ready, one per item
//  cfg_ch   in   attribute   valid & ready (always ready)
//
// Put, backspace and read pass the execute and done states to the output register.
// Clear walks every cell once.
// A scroll reads and writes back each moved cell, then zeroes the last row,
// all through the single address counter and the store's one write port.
// After reset a zeroing pass over every cell runs with in ready low.
// A stalled result waits in the output register; the next item is taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tcc_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tcc_chan_if.sink   in_ch,
  tcc_chan_if.source out_ch,
  tcc_chan_if.sink   cfg_ch
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_A  = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

  // state
  tcc_state_t     state_r, state_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [7:0]     attr_r, attr_nxt;
  logic           scrolled_r, scrolled_nxt;
  logic           out_valid_r, out_valid_nxt;
  tcc_out_t       out_data_r, out_data_nxt;

  // latched item
  tcc_action_t    op_r, op_nxt;
  logic [7:0]     char_r, char_nxt;
  logic [CW-1:0]  pcol_r, pcol_nxt;
  logic [RW-1:0]  prow_r, prow_nxt;

  // store port
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata, mem_rdata;

  logic           in_xfer, out_free, sweep_last;
  logic [AW-1:0]  cell_addr;
  logic [CW-1:0]  sel_col, bsp_col, put_col;
  logic [RW-1:0]  sel_row, bsp_row, put_row;
  logic           put_wrap;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign sweep_last = (sweep_r == LAST_CELL);
  assign cell_addr  = AW'(prow_r) * COLS_A + AW'(pcol_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // position of an incoming put or read, saturated to the grid
  always_comb begin
    if (in_ch.data.at_cursor) begin
      sel_col = cur_col_r;
      sel_row = cur_row_r;
    end else begin
      sel_col = (int'(in_ch.data.col) >= COLUMNS) ? LAST_COL : CW'(in_ch.data.col);
      sel_row = (int'(in_ch.data.row) >= ROWS)    ? LAST_ROW : RW'(in_ch.data.row);
    end
  end

  // backspace target: one cell back, stays at cell zero
  always_comb begin
    if (cur_col_r != '0) begin
      bsp_col = cur_col_r - CW'(1);
      bsp_row = cur_row_r;
    end else if (cur_row_r != '0) begin
      bsp_col = LAST_COL;
      bsp_row = cur_row_r - RW'(1);
    end else begin
      bsp_col = '0;
      bsp_row = '0;
    end
  end

  // cursor after a put; wrap flags a run past the last row
  always_comb begin
    put_col  = pcol_r;
    put_row  = prow_r;
    put_wrap = 1'b0;
    if (char_r == CODE_NEWLINE || (char_r != CODE_BLANK && pcol_r == LAST_COL)) begin
      put_col = '0;
      if (prow_r == LAST_ROW) begin
        put_wrap = 1'b1;
      end else begin
        put_row = prow_r + RW'(1);
      end
    end else if (char_r != CODE_BLANK) begin
      put_col = pcol_r + CW'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == ACT_CLEAR) begin
          state_nxt = ST_FILL;
        end else if (op_r == ACT_PUT && put_wrap) begin
          state_nxt = ST_SCR_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        if (sweep_last) state_nxt = ST_DONE;
      end
      ST_SCR_RD: state_nxt = ST_SCR_WR;
      ST_SCR_WR: begin
        state_nxt = sweep_last ? ST_ZERO : ST_SCR_RD;
      end
      ST_ZERO: begin
        if (sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // datapath and store control
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = sweep_r;
    sweep_nxt     = sweep_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scrolled_nxt  = scrolled_r;
    op_nxt        = op_r;
    char_nxt      = char_r;
    pcol_nxt      = pcol_r;
    prow_nxt      = prow_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    attr_nxt      = cfg_ch.valid ? cfg_ch.data : attr_r;

    case (state_r)
      // zero every cell after reset
      ST_INIT: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
      end
      // latch item and its resolved position
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt       = in_ch.data.action;
          char_nxt     = in_ch.data.char_code;
          pcol_nxt     = (in_ch.data.action == ACT_BACKSPACE) ? bsp_col : sel_col;
          prow_nxt     = (in_ch.data.action == ACT_BACKSPACE) ? bsp_row : sel_row;
          scrolled_nxt = 1'b0;
          sweep_nxt    = '0;
        end
      end
      // one cell access (none for clear)
      ST_EXEC: begin
        case (op_r)
          ACT_PUT: begin
            mem_waddr = cell_addr;
            mem_we    = (char_r != CODE_NEWLINE);
            mem_wdata = {attr_r, (char_r == CODE_BLANK) ? CODE_SPACE : char_r};
            if (put_wrap) begin
              cur_col_nxt  = '0;
              cur_row_nxt  = LAST_ROW;
              scrolled_nxt = 1'b1;
              sweep_nxt    = COLS_A;
            end else begin
              cur_col_nxt = put_col;
              cur_row_nxt = put_row;
            end
          end
          ACT_BACKSPACE: begin
            mem_we      = 1'b1;
            mem_waddr   = cell_addr;
            mem_wdata   = {attr_r, CODE_SPACE};
            cur_col_nxt = pcol_r;
            cur_row_nxt = prow_r;
          end
          ACT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr;
          end
          default: ;
        endcase
      end
      // clear screen sweep
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_r, CODE_SPACE};
        if (sweep_last) begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      // scroll: fetch source cell
      ST_SCR_RD: begin
        mem_re = 1'b1;
      end
      // scroll: store it one row up
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r - COLS_A;
        mem_wdata = mem_rdata;
        sweep_nxt = sweep_last ? LAST_ROW_A : sweep_r + AW'(1);
      end
      // scroll: blank row is all zero
      ST_ZERO: begin
        mem_we = 1'b1;
        if (!sweep_last) sweep_nxt = sweep_r + AW'(1);
      end
      // result into the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cursor_col = 7'(cur_col_r);
          out_data_nxt.cursor_row = 5'(cur_row_r);
          out_data_nxt.scrolled   = scrolled_r;
          out_data_nxt.cell_char  = (op_r == ACT_READ) ? mem_rdata[7:0]  : '0;
          out_data_nxt.cell_attr  = (op_r == ACT_READ) ? mem_rdata[15:8] : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    pcol_r     <= pcol_nxt;
    prow_r     <= prow_nxt;
    scrolled_r <= scrolled_nxt;
    out_data_r <= out_data_nxt;
  end

  // cell store
  tcc_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (16)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // checks
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_col_r) < COLUMNS) && (int'(cur_row_r) < ROWS))
    else $error("cursor outside grid");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && scrolled_r) |-> (cur_col_r == '0 && cur_row_r == LAST_ROW))
    else $error("scroll left cursor off the last row start");

  a_sweep_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCR_WR || state_r == ST_FILL || state_r == ST_ZERO) |=> !in_xfer)
    else $error("input taken during store sweep");

endmodule : text_console_cell_writer
`default_nettype wire

@@ src/tcc_cell_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_cell_ram: cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcc_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tcc_cell_ram
`default_nettype wire
